// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kthsel_pkg.sv =====
// Shared types and constants for the k-th smallest selector.
package kthsel_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 32;

  localparam int KIND_W  = 2;
  localparam int ELEM_W  = 32;
  localparam int RANK_W  = 12;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = $clog2(2 * DEPTH + 1);
  localparam int CMP_W   = (RANK_W > SUM_W) ? RANK_W : SUM_W;

  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ELEM_W-1:0] value;
    logic [RANK_W-1:0] rank;
  } in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [STAT_W-1:0] status;
  } out_t;

  // Control for one row of cells: shift enable and the word entering cell 0.
  typedef struct packed {
    logic                  shift;
    logic [VALUE_BITS-1:0] din;
  } chain_ctrl_t;

endpackage

// ===== rtl/kthsel_cell.sv =====
// One storage cell of a list row: takes its neighbor's word on a shift.
module kthsel_cell
  import kthsel_pkg::*;
(
  input  logic                  clk,
  input  logic                  shift,
  input  logic [VALUE_BITS-1:0] d,
  output logic [VALUE_BITS-1:0] q
);

  logic [VALUE_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/kthsel_chain.sv =====
// Row of DEPTH cells holding one list; new words enter at cell 0, head is the last cell.
module kthsel_chain
  import kthsel_pkg::*;
(
  input  logic                  clk,
  input  chain_ctrl_t           ctrl,
  output logic [VALUE_BITS-1:0] head
);

  logic [VALUE_BITS-1:0] tap [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      kthsel_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d     (ctrl.din),
        .q     (tap[i])
      );
    end else begin : g_rest
      kthsel_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d     (tap[i-1]),
        .q     (tap[i])
      );
    end
  end

  assign head = tap[DEPTH-1];

endmodule

// ===== rtl/kth_smallest_of_two_sorted_lists_core.sv =====
// K-th smallest of two loaded lists: each list lives in a row of DEPTH shift cells.
// A load beat (kind first or second) shifts its value into cell 0 of that list's row;
// a load into a full row is dropped and sets the overflow flag. A query beat (kind
// query) answers with the rank-th value of a two-pointer merge of the lists as loaded
// (ties go to the first list), then empties both lists and clears the flag. An overflow
// answer (status 2) or an out-of-range answer (rank 0 or above the total, status 1)
// carries element 0 and goes from the flush state into the output register. For a found
// answer the rows first shift until each list's oldest word sits in the last cell, the
// merge state then pops one word per cycle from whichever head wins the compare, and
// the flush state loads the output register once it is free.
// Loads are taken while a result waits on out_stall; nothing else is taken while a query
// is in progress.
module kth_smallest_of_two_sorted_lists_core
  import kthsel_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALIGN,
    S_MERGE,
    S_FLUSH
  } state_t;

  state_t                state_r,     state_nxt;
  logic [CNT_W-1:0]      ca_r,        ca_nxt;       // first list fill
  logic [CNT_W-1:0]      cb_r,        cb_nxt;       // second list fill
  logic                  ovf_r,       ovf_nxt;
  logic [CNT_W-1:0]      ra_r,        ra_nxt;       // words left in first list during merge
  logic [CNT_W-1:0]      rb_r,        rb_nxt;
  logic [CNT_W-1:0]      ala_r,       ala_nxt;      // alignment shifts left
  logic [CNT_W-1:0]      alb_r,       alb_nxt;
  logic [RANK_W-1:0]     kleft_r,     kleft_nxt;    // pops still to do
  logic [VALUE_BITS-1:0] res_elem_r,  res_elem_nxt;
  logic [STAT_W-1:0]     res_stat_r,  res_stat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r,  out_data_nxt;

  chain_ctrl_t           ctrl_a, ctrl_b;
  logic [VALUE_BITS-1:0] head_a, head_b;
  logic [VALUE_BITS-1:0] value_in;
  logic [CMP_W-1:0]      rank_ext, total;
  logic                  in_acc, take_a;

  kthsel_chain u_chain_a (
    .clk  (clk),
    .ctrl (ctrl_a),
    .head (head_a)
  );

  kthsel_chain u_chain_b (
    .clk  (clk),
    .ctrl (ctrl_b),
    .head (head_b)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign value_in  = VALUE_BITS'(in_data.value);
  assign rank_ext  = CMP_W'(in_data.rank);
  assign total     = CMP_W'(ca_r) + CMP_W'(cb_r);
  // Merge pick: first list wins unless it is empty, or the second list is non-empty and its head is smaller.
  assign take_a    = (ra_r != '0) && ((rb_r == '0) || (head_a <= head_b));

  always_comb begin
    state_nxt     = state_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    ovf_nxt       = ovf_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    ala_nxt       = ala_r;
    alb_nxt       = alb_r;
    kleft_nxt     = kleft_r;
    res_elem_nxt  = res_elem_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctrl_a.shift  = 1'b0;
    ctrl_a.din    = value_in;
    ctrl_b.shift  = 1'b0;
    ctrl_b.din    = value_in;

    // Output beat taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.kind)
            KIND_FIRST: begin
              if (ca_r == CNT_W'(DEPTH)) begin
                ovf_nxt = 1'b1;
              end else begin
                ctrl_a.shift = 1'b1;
                ca_nxt       = ca_r + CNT_W'(1);
              end
            end
            KIND_SECOND: begin
              if (cb_r == CNT_W'(DEPTH)) begin
                ovf_nxt = 1'b1;
              end else begin
                ctrl_b.shift = 1'b1;
                cb_nxt       = cb_r + CNT_W'(1);
              end
            end
            KIND_QUERY: begin
              ra_nxt       = ca_r;
              rb_nxt       = cb_r;
              ala_nxt      = CNT_W'(DEPTH) - ca_r;
              alb_nxt      = CNT_W'(DEPTH) - cb_r;
              kleft_nxt    = in_data.rank;
              ca_nxt       = '0;
              cb_nxt       = '0;
              ovf_nxt      = 1'b0;
              res_elem_nxt = '0;
              if (ovf_r) begin
                res_stat_nxt = ST_OVERFLOW;
                state_nxt    = S_FLUSH;
              end else if ((rank_ext == '0) || (rank_ext > total)) begin
                res_stat_nxt = ST_RANGE;
                state_nxt    = S_FLUSH;
              end else begin
                res_stat_nxt = ST_FOUND;
                state_nxt    = S_ALIGN;
              end
            end
            default: begin
              // unused kind: dropped without effect
            end
          endcase
        end
      end

      S_ALIGN: begin
        // Walk each row until its oldest word reaches the head cell.
        if (ala_r != '0) begin
          ctrl_a.shift = 1'b1;
          ala_nxt      = ala_r - CNT_W'(1);
        end
        if (alb_r != '0) begin
          ctrl_b.shift = 1'b1;
          alb_nxt      = alb_r - CNT_W'(1);
        end
        if ((ala_r == '0) && (alb_r == '0)) begin
          state_nxt = S_MERGE;
        end
      end

      S_MERGE: begin
        if (take_a) begin
          ctrl_a.shift = 1'b1;
          ra_nxt       = ra_r - CNT_W'(1);
          res_elem_nxt = head_a;
        end else begin
          ctrl_b.shift = 1'b1;
          rb_nxt       = rb_r - CNT_W'(1);
          res_elem_nxt = head_b;
        end
        kleft_nxt = kleft_r - RANK_W'(1);
        if (kleft_r == RANK_W'(1)) begin
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.element = ELEM_W'(res_elem_r);
          out_data_nxt.status  = res_stat_r;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ca_r        <= '0;
      cb_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ca_r        <= ca_nxt;
      cb_r        <= cb_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      ra_r        <= ra_nxt;
      rb_r        <= rb_nxt;
      ala_r       <= ala_nxt;
      alb_r       <= alb_nxt;
      kleft_r     <= kleft_nxt;
      res_elem_r  <= res_elem_nxt;
      res_stat_r  <= res_stat_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/kthsel_checker.sv =====
// Port-level checks for the k-th smallest selector, bound to the top level.
`include "assert_macros.svh"

module kthsel_checker
  import kthsel_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `ASSERT_IMPL(a_miss_zero, out_valid && (out_data.status != ST_FOUND), out_data.element == '0, "non-found result with nonzero element")
  `ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (in_data.kind == KIND_QUERY), in_stall, "query beat not followed by busy")
  `ASSERT_NEXT(a_load_silent, !out_valid && in_valid && !in_stall && (in_data.kind != KIND_QUERY), !out_valid, "load beat produced a result")
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat dropped or changed")

endmodule

bind kth_smallest_of_two_sorted_lists_core kthsel_checker u_kthsel_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the k-th smallest selector: predicts each answer, checks each result beat.
module testbench
  import kthsel_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Bound on a found answer: the rows shift at most DEPTH times, then pop at most 2*DEPTH words.
  localparam int LONGEST_ANSWER = 2 + DEPTH + 2 * DEPTH;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 5 * (LONGEST_ANSWER + HOLD_CYCLES + 16);
  localparam int RANDOM_BEATS   = 680;

  typedef bit [VALUE_BITS-1:0] word_q_t[$];

  class answer_checker;
    bit [VALUE_BITS-1:0] first_words[$];
    bit [VALUE_BITS-1:0] second_words[$];
    bit                  overflow_seen;
    out_t                answers_due[$];
    int                  errors;

    // k-th word of a two-pointer merge, ties taken from the first list
    function bit [ELEM_W-1:0] merge_pick(int k);
      int a;
      int b;
      bit [ELEM_W-1:0] pick;
      a = 0;
      b = 0;
      pick = '0;
      for (int n = 0; n < k; n++) begin
        if (a < first_words.size() &&
            (b >= second_words.size() || first_words[a] <= second_words[b])) begin
          pick = first_words[a];
          a++;
        end else begin
          pick = second_words[b];
          b++;
        end
      end
      return pick;
    endfunction

    function void note_beat(in_t beat);
      out_t due;
      int total;
      case (beat.kind)
        KIND_FIRST: begin
          if (first_words.size() < DEPTH) first_words.push_back(beat.value[VALUE_BITS-1:0]);
          else overflow_seen = 1'b1;
        end
        KIND_SECOND: begin
          if (second_words.size() < DEPTH) second_words.push_back(beat.value[VALUE_BITS-1:0]);
          else overflow_seen = 1'b1;
        end
        KIND_QUERY: begin
          total = first_words.size() + second_words.size();
          due.element = '0;
          if (overflow_seen) begin
            due.status = ST_OVERFLOW;
          end else if (beat.rank == 0 || int'(beat.rank) > total) begin
            due.status = ST_RANGE;
          end else begin
            due.element = merge_pick(int'(beat.rank));
            due.status  = ST_FOUND;
          end
          answers_due.push_back(due);
          first_words.delete();
          second_words.delete();
          overflow_seen = 1'b0;
        end
        default: ;  // unused kind: no effect
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (answers_due.size() == 0) begin
        $error("result beat with no answer due: element %h status %0d",
               got.element, got.status);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (got.element !== want.element) begin
        $error("element: expected %h, actual %h", want.element, got.element);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  answer_checker sb;
  int send_calm;
  int take_calm;
  int beats_sent;
  int quiet_cycles;
  bit hold_armed;

  kth_smallest_of_two_sorted_lists_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // random idle gap before each beat, with occasional stretches of back-to-back beats
  function automatic int idle_cycles(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic word_q_t make_run(int n, bit narrow, bit ordered);
    word_q_t run;
    bit [VALUE_BITS-1:0] key;
    int j;
    for (int i = 0; i < n; i++) run.push_back(narrow ? $urandom_range(0, 15) : $urandom);
    if (ordered) begin
      for (int i = 1; i < run.size(); i++) begin
        key = run[i];
        j = i - 1;
        while (j >= 0 && run[j] > key) begin
          run[j + 1] = run[j];
          j--;
        end
        run[j + 1] = key;
      end
    end
    return run;
  endfunction

  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [ELEM_W-1:0] value,
                           input logic [RANK_W-1:0] rank);
    int gap;
    in_t beat;
    beat.kind  = kind;
    beat.value = value;
    beat.rank  = rank;
    gap = idle_cycles(send_calm);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    if (kind != KIND_UNUSED) beats_sent++;
  endtask

  task automatic ask_rank(input int rank);
    send_beat(KIND_QUERY, $urandom, rank[RANK_W-1:0]);
  endtask

  // interleave the two lists at random; noise adds ignored beats
  task automatic load_lists(input word_q_t f, input word_q_t s, input bit noise);
    int fi;
    int si;
    bit take_first;
    fi = 0;
    si = 0;
    while (fi < f.size() || si < s.size()) begin
      if (noise && $urandom_range(0, 24) == 0)
        send_beat(KIND_UNUSED, $urandom, RANK_W'($urandom_range(0, 4095)));
      take_first = (si >= s.size()) || (fi < f.size() && $urandom_range(0, 1) == 1);
      if (take_first) begin
        send_beat(KIND_FIRST, f[fi], RANK_W'($urandom_range(0, 4095)));
        fi++;
      end else begin
        send_beat(KIND_SECOND, s[si], RANK_W'($urandom_range(0, 4095)));
        si++;
      end
    end
  endtask

  task automatic quiet_until_drained(input int settle);
    in_valid <= 1'b0;
    // let the monitor note the last beat taken before the queue is checked
    @(posedge clk);
    while (sb.answers_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // result side: random stall per beat, one long hold when armed
  initial begin
    int gap;
    out_stall = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_armed) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_armed = 1'b0;
      end
      gap = idle_cycles(take_calm);
      repeat (gap) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL kth_smallest_of_two_sorted_lists_core");
        $finish;
      end
    end
  end

  initial begin
    int random_start;
    int nf;
    int ns;
    int total;
    int rank;
    int pick;
    bit narrow;
    bit ordered;
    sb = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    send_calm    = 0;
    take_calm    = 0;
    beats_sent   = 0;
    quiet_cycles = 0;
    hold_armed   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty lists, rank zero, extremes, ties, unsorted, unused kind
    ask_rank(1);
    send_beat(KIND_FIRST, 32'h0000_0000, 12'hFFF);
    send_beat(KIND_SECOND, 32'hFFFF_FFFF, 12'h000);
    ask_rank(0);
    send_beat(KIND_FIRST, 32'h0000_0000, 12'h000);
    send_beat(KIND_FIRST, 32'hFFFF_FFFF, 12'hFFF);
    send_beat(KIND_SECOND, 32'h0000_0000, 12'h555);
    ask_rank(3);
    send_beat(KIND_FIRST, 32'd7, 12'hAAA);
    send_beat(KIND_FIRST, 32'd7, 12'h000);
    send_beat(KIND_SECOND, 32'd7, 12'h000);
    ask_rank(4);
    send_beat(KIND_FIRST, 32'd9, 12'h000);
    send_beat(KIND_FIRST, 32'd1, 12'h000);
    send_beat(KIND_SECOND, 32'd5, 12'h000);
    ask_rank(2);
    send_beat(KIND_SECOND, 32'd3, 12'h000);
    send_beat(KIND_UNUSED, 32'hFFFF_FFFF, 12'hFFF);
    send_beat(KIND_SECOND, 32'd4, 12'h000);
    send_beat(KIND_QUERY, 32'hFFFF_FFFF, 12'd2);
    ask_rank(12'hFFF);
    send_beat(KIND_FIRST, 32'd100, 12'h000);
    send_beat(KIND_SECOND, 32'd100, 12'h000);
    ask_rank(1);

    // sender pause: let every answer come back before going on
    quiet_until_drained(40);

    // random: mostly short sorted lists then a query
    hold_armed   = 1'b1;
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      nf = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
      ns = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
      narrow  = ($urandom_range(0, 2) == 0);
      ordered = ($urandom_range(0, 9) != 0);
      load_lists(make_run(nf, narrow, ordered), make_run(ns, narrow, ordered), 1'b1);
      total = nf + ns;
      pick  = $urandom_range(0, 9);
      case (pick)
        0:       rank = 0;
        1:       rank = total + 1;
        2:       rank = $urandom_range(0, 4095);
        default: rank = (total == 0) ? 1 : $urandom_range(1, total);
      endcase
      ask_rank(rank);
      if ($urandom_range(0, 7) == 0) ask_rank($urandom_range(0, 3));  // back-to-back query
    end

    quiet_until_drained(LONGEST_ANSWER + 64);
    if (sb.errors == 0) begin
      $display("PASS kth_smallest_of_two_sorted_lists_core");
    end else begin
      $display("FAIL kth_smallest_of_two_sorted_lists_core");
    end
    $finish;
  end

endmodule
